// File: rtl/core/ppt_pkg.sv
// Shared types, constants and the output rounding function for the projective
// point transform core. No dependencies.
package ppt_pkg;

  localparam int CoordW  = 32;
  localparam int ProdW   = 64;
  localparam int QuoW    = 33;              // quotient bits: Q16.17 before rounding
  localparam int NumCell = QuoW;            // one division cell per quotient bit
  localparam int CfgIdxW = 4;

  localparam logic signed [ProdW-1:0] OneQ38 = 64'sd1 <<< 38;
  localparam logic signed [CoordW-1:0] SatMax = 32'sh7fffffff;
  localparam logic signed [CoordW-1:0] SatMin = 32'sh80000000;
  localparam logic signed [CoordW-1:0] CoefOne = 32'sh01000000;  // 1.0 in Q8.24

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_XX = 4'd0,
    REG_COEF_XY = 4'd1,
    REG_COEF_XT = 4'd2,
    REG_COEF_YX = 4'd3,
    REG_COEF_YY = 4'd4,
    REG_COEF_YT = 4'd5,
    REG_COEF_WX = 4'd6,
    REG_COEF_WY = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
  } point_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] warped_x;
    logic signed [CoordW-1:0] warped_y;
    logic signed [CoordW-1:0] inv_w;
    logic                     w_zero;
    logic                     clipped;
  } point_out_t;

  typedef struct packed {
    logic signed [CoordW-1:0] xx;
    logic signed [CoordW-1:0] xy;
    logic signed [CoordW-1:0] xt;
    logic signed [CoordW-1:0] yx;
    logic signed [CoordW-1:0] yy;
    logic signed [CoordW-1:0] yt;
    logic signed [CoordW-1:0] wx;
    logic signed [CoordW-1:0] wy;
  } coef_t;

  // One division lane: partial remainder, numerator bits still to shift in,
  // quotient collected so far, and the sign/overflow of the final result
  typedef struct packed {
    logic [ProdW-1:0] rem;
    logic [QuoW-1:0]  frac;
    logic [QuoW-1:0]  quo;
    logic             neg;
    logic             ovf;
    logic             num_neg;
  } div_lane_t;

  // Everything carried along the divider chain for one point
  typedef struct packed {
    div_lane_t        lx;
    div_lane_t        ly;
    div_lane_t        lw;
    logic [ProdW-1:0] den;
    logic             w_zero;
  } div_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] value;
    logic                     clip;
  } sat_res_t;

  // Round Q16.17 quotient to Q16.16 (ties away from zero), apply sign, saturate
  function automatic sat_res_t round_sat(div_lane_t lane);
    sat_res_t       res;
    logic [QuoW:0]  sum;
    logic [QuoW-1:0] m;
    sum = {1'b0, lane.quo} + {{QuoW{1'b0}}, 1'b1};
    m   = sum[QuoW:1];
    res.clip  = 1'b0;
    res.value = SatMax;
    if (lane.ovf) begin
      res.clip  = 1'b1;
      res.value = lane.neg ? SatMin : SatMax;
    end else if (!lane.neg) begin
      if (m[QuoW-1] | m[QuoW-2]) begin
        res.clip  = 1'b1;
        res.value = SatMax;
      end else begin
        res.value = signed'(m[CoordW-1:0]);
      end
    end else begin
      if (m[QuoW-1] | (m[QuoW-2] & (|m[QuoW-3:0]))) begin
        res.clip  = 1'b1;
        res.value = SatMin;
      end else if (m[QuoW-2]) begin
        res.value = SatMin;
      end else begin
        res.value = signed'(-m[CoordW-1:0]);
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/core/ppt_front.sv
// Front end: products, row sums and divider setup, three pipeline stages.
// Depends on ppt_pkg.
module ppt_front (
  input  logic               clk,
  input  logic               rst,
  input  ppt_pkg::coef_t     coef,
  input  logic               in_valid,
  output logic               in_ready,
  input  ppt_pkg::point_in_t in_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output ppt_pkg::div_item_t dn_data
);

  logic s1_v, s2_v, s3_v;
  logic rdy1, rdy2, rdy3;
  logic signed [ppt_pkg::ProdW-1:0] p_xx, p_xy, p_yx, p_yy, p_wx, p_wy;
  logic signed [ppt_pkg::ProdW-1:0] xn, yn, wd;
  ppt_pkg::div_item_t item_next;
  ppt_pkg::div_item_t item;

  // Stage advance: a stage takes new data when empty or when it drains
  assign rdy3     = !s3_v || dn_ready;
  assign rdy2     = !s2_v || rdy3;
  assign rdy1     = !s1_v || rdy2;
  assign in_ready = rdy1;
  assign dn_valid = s3_v;
  assign dn_data  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      if (rdy1) s1_v <= in_valid;
      if (rdy2) s2_v <= s1_v;
      if (rdy3) s3_v <= s2_v;
    end
  end

  // Stage 1: six 32x32 signed products
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      p_xx <= ppt_pkg::ProdW'(in_data.point_x) * ppt_pkg::ProdW'(coef.xx);
      p_xy <= ppt_pkg::ProdW'(in_data.point_y) * ppt_pkg::ProdW'(coef.xy);
      p_yx <= ppt_pkg::ProdW'(in_data.point_x) * ppt_pkg::ProdW'(coef.yx);
      p_yy <= ppt_pkg::ProdW'(in_data.point_y) * ppt_pkg::ProdW'(coef.yy);
      p_wx <= ppt_pkg::ProdW'(in_data.point_x) * ppt_pkg::ProdW'(coef.wx);
      p_wy <= ppt_pkg::ProdW'(in_data.point_y) * ppt_pkg::ProdW'(coef.wy);
    end
  end

  // Stage 2: row sums in Q.38 (products floored by 4, translation scaled up)
  always_ff @(posedge clk) begin
    if (rdy2 && s1_v) begin
      xn <= (p_xx >>> 2) + (p_xy >>> 2) + (ppt_pkg::ProdW'(coef.xt) <<< 14);
      yn <= (p_yx >>> 2) + (p_yy >>> 2) + (ppt_pkg::ProdW'(coef.yt) <<< 14);
      wd <= (p_wx >>> 2) + (p_wy >>> 2) + ppt_pkg::OneQ38;
    end
  end

  // Stage 3: magnitudes, integer-part overflow test, initial remainder
  function automatic ppt_pkg::div_lane_t lane_setup(logic signed [ppt_pkg::ProdW-1:0] num,
                                                    logic [ppt_pkg::ProdW-1:0] den,
                                                    logic den_neg);
    ppt_pkg::div_lane_t l;
    logic [ppt_pkg::ProdW-1:0] n;
    n         = num[ppt_pkg::ProdW-1] ? ppt_pkg::ProdW'(-num) : ppt_pkg::ProdW'(num);
    l.rem     = n >> 16;
    l.frac    = {n[15:0], 17'b0};
    l.quo     = '0;
    l.neg     = num[ppt_pkg::ProdW-1] ^ den_neg;
    l.ovf     = (n >> 16) >= den;
    l.num_neg = num[ppt_pkg::ProdW-1];
    return l;
  endfunction

  always_comb begin
    logic [ppt_pkg::ProdW-1:0] d;
    logic                      dneg;
    dneg             = wd[ppt_pkg::ProdW-1];
    d                = dneg ? ppt_pkg::ProdW'(-wd) : ppt_pkg::ProdW'(wd);
    item_next.den    = d;
    item_next.w_zero = (wd == '0);
    item_next.lx     = lane_setup(xn, d, dneg);
    item_next.ly     = lane_setup(yn, d, dneg);
    item_next.lw     = lane_setup(ppt_pkg::OneQ38, d, dneg);
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v) item <= item_next;
  end

endmodule

// File: rtl/core/ppt_div_cell.sv
// One restoring-division cell: one quotient bit for each of three lanes.
// Depends on ppt_pkg.
module ppt_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  ppt_pkg::div_item_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output ppt_pkg::div_item_t dn_data
);

  logic               v;
  ppt_pkg::div_item_t item;
  ppt_pkg::div_item_t item_next;

  function automatic ppt_pkg::div_lane_t step(ppt_pkg::div_lane_t l,
                                              logic [ppt_pkg::ProdW-1:0] den);
    ppt_pkg::div_lane_t o;
    logic [ppt_pkg::ProdW:0] t;
    logic [ppt_pkg::ProdW:0] diff;
    logic                    ge;
    t      = {l.rem, l.frac[ppt_pkg::QuoW-1]};
    diff   = t - {1'b0, den};
    ge     = t >= {1'b0, den};
    o      = l;
    o.rem  = ge ? diff[ppt_pkg::ProdW-1:0] : t[ppt_pkg::ProdW-1:0];
    o.frac = {l.frac[ppt_pkg::QuoW-2:0], 1'b0};
    o.quo  = {l.quo[ppt_pkg::QuoW-2:0], ge};
    return o;
  endfunction

  assign up_ready = !v || dn_ready;
  assign dn_valid = v;
  assign dn_data  = item;

  always_comb begin
    item_next    = up_data;
    item_next.lx = step(up_data.lx, up_data.den);
    item_next.ly = step(up_data.ly, up_data.den);
    item_next.lw = step(up_data.lw, up_data.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) item <= item_next;
  end

endmodule

// File: rtl/core/ppt_back.sv
// Back end: rounding, saturation, zero-w override and the output register.
// Depends on ppt_pkg.
module ppt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  ppt_pkg::div_item_t  up_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ppt_pkg::point_out_t out_data
);

  logic                v;
  ppt_pkg::point_out_t res;
  ppt_pkg::point_out_t res_next;
  ppt_pkg::sat_res_t   rx, ry, rw;

  assign up_ready  = !v || out_ready;
  assign out_valid = v;
  assign out_data  = res;

  // Final result, with zero w forcing saturated values
  always_comb begin
    rx = ppt_pkg::round_sat(up_data.lx);
    ry = ppt_pkg::round_sat(up_data.ly);
    rw = ppt_pkg::round_sat(up_data.lw);
    if (up_data.w_zero) begin
      res_next.warped_x = up_data.lx.num_neg ? ppt_pkg::SatMin : ppt_pkg::SatMax;
      res_next.warped_y = up_data.ly.num_neg ? ppt_pkg::SatMin : ppt_pkg::SatMax;
      res_next.inv_w    = ppt_pkg::SatMax;
      res_next.w_zero   = 1'b1;
      res_next.clipped  = 1'b1;
    end else begin
      res_next.warped_x = rx.value;
      res_next.warped_y = ry.value;
      res_next.inv_w    = rw.value;
      res_next.w_zero   = 1'b0;
      res_next.clipped  = rx.clip | ry.clip | rw.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) res <= res_next;
  end

endmodule

// File: rtl/core/projective_point_transform_core.sv
// Top level of the projective point transform: coefficient registers, front
// end, chain of division cells and back end. Depends on ppt_pkg and submodules.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    in_data  (point_x, point_y)
//   out       output     out_valid / out_ready  out_data (warped_x .. clipped)
//   cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Sustained rate is one point per cycle while out_ready is high. The path is
// three front stages (multiply, row sum, divider setup), 33 division cells
// (a quotient bit of all three lanes per cell) and the output register.
// Every stage holds its item while the next is full and stalled, so a stall
// on out_ready backs up stage by stage. Reset clears all valid bits and loads
// the identity matrix into the coefficient registers; cfg_ready is always high.
module projective_point_transform_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ppt_pkg::point_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ppt_pkg::point_out_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppt_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [ppt_pkg::CoordW-1:0]     cfg_data
);

  ppt_pkg::coef_t     coef;
  logic               chain_valid [ppt_pkg::NumCell+1];
  logic               chain_ready [ppt_pkg::NumCell+1];
  ppt_pkg::div_item_t chain_data  [ppt_pkg::NumCell+1];

  assign cfg_ready = 1'b1;

  // Coefficient registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '{xx: ppt_pkg::CoefOne, yy: ppt_pkg::CoefOne, default: '0};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ppt_pkg::REG_COEF_XX: coef.xx <= signed'(cfg_data);
        ppt_pkg::REG_COEF_XY: coef.xy <= signed'(cfg_data);
        ppt_pkg::REG_COEF_XT: coef.xt <= signed'(cfg_data);
        ppt_pkg::REG_COEF_YX: coef.yx <= signed'(cfg_data);
        ppt_pkg::REG_COEF_YY: coef.yy <= signed'(cfg_data);
        ppt_pkg::REG_COEF_YT: coef.yt <= signed'(cfg_data);
        ppt_pkg::REG_COEF_WX: coef.wx <= signed'(cfg_data);
        ppt_pkg::REG_COEF_WY: coef.wy <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  ppt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .coef     (coef),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_data  (chain_data[0])
  );

  // Division chain, one quotient bit per cell
  for (genvar g = 0; g < ppt_pkg::NumCell; g++) begin : g_cell
    ppt_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[g]),
      .up_ready (chain_ready[g]),
      .up_data  (chain_data[g]),
      .dn_valid (chain_valid[g+1]),
      .dn_ready (chain_ready[g+1]),
      .dn_data  (chain_data[g+1])
    );
  end

  ppt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (chain_valid[ppt_pkg::NumCell]),
    .up_ready  (chain_ready[ppt_pkg::NumCell]),
    .up_data   (chain_data[ppt_pkg::NumCell]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: bench/tb.sv
// Testbench for projective_point_transform_core: directed table plus random
// points and coefficient sets, checked against a fixed-point predictor.
// Depends on ppt_pkg and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 20000;
  localparam int Drain      = 60;
  localparam logic [ppt_pkg::CfgIdxW-1:0] RegPastEnd = 4'd15;
  localparam logic signed [31:0] OneQ24 = 32'sh01000000;
  localparam logic signed [31:0] OneQ16 = 32'sh00010000;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  ppt_pkg::point_in_t  in_data;
  ppt_pkg::point_out_t out_data;
  logic [ppt_pkg::CfgIdxW-1:0] cfg_index;
  logic [ppt_pkg::CoordW-1:0]  cfg_data;

  projective_point_transform_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the coefficient registers, in register index order
  logic signed [31:0] coef_shadow [8];
  ppt_pkg::point_out_t warp_expected [$];
  int  errors = 0;
  int  in_idle_pct = 0, out_stall_pct = 0;
  bit  typed_pending = 0;
  ppt_pkg::point_out_t typed_result;
  int  quiet_cycles = 0;

  // Directed rows: optional coefficient load before the point, optional typed result
  typedef struct {
    bit                  load;
    ppt_pkg::coef_t      coefs;
    ppt_pkg::point_in_t  pt;
    bit                  typed;
    ppt_pkg::point_out_t res;
  } dir_row_t;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint row_total(longint x, longint y, logic signed [31:0] cx,
                                       logic signed [31:0] cy, longint t38);
    longint px, py;
    px = x * longint'(cx);
    py = y * longint'(cy);
    return (px >>> 2) + (py >>> 2) + t38;
  endfunction

  // num/den in Q16.16, ties away from zero, saturated
  function automatic logic signed [31:0] quot_q16(longint num, longint den, ref bit clip);
    bit neg;
    logic [127:0] n, d, q17, m;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? 128'(-num) : 128'(num);
    d = (den < 0) ? 128'(-den) : 128'(den);
    q17 = (n << 17) / d;
    if (q17 >= (128'd1 << 33)) begin
      clip = 1;
      return neg ? ppt_pkg::SatMin : ppt_pkg::SatMax;
    end
    m = (q17 + 1) >> 1;
    if (!neg) begin
      if (m > 128'h7fffffff) begin
        clip = 1;
        return ppt_pkg::SatMax;
      end
      return m[31:0];
    end
    if (m > 128'h80000000) begin
      clip = 1;
      return ppt_pkg::SatMin;
    end
    return -m[31:0];
  endfunction

  function automatic ppt_pkg::point_out_t warp_point(ppt_pkg::point_in_t p);
    ppt_pkg::point_out_t r;
    longint x, y, xn, yn, w;
    bit clip;
    x = longint'(p.point_x);
    y = longint'(p.point_y);
    clip = 0;
    xn = row_total(x, y, coef_shadow[ppt_pkg::REG_COEF_XX], coef_shadow[ppt_pkg::REG_COEF_XY],
                   longint'(coef_shadow[ppt_pkg::REG_COEF_XT]) * 16384);
    yn = row_total(x, y, coef_shadow[ppt_pkg::REG_COEF_YX], coef_shadow[ppt_pkg::REG_COEF_YY],
                   longint'(coef_shadow[ppt_pkg::REG_COEF_YT]) * 16384);
    w  = row_total(x, y, coef_shadow[ppt_pkg::REG_COEF_WX], coef_shadow[ppt_pkg::REG_COEF_WY],
                   ppt_pkg::OneQ38);
    r.w_zero = (w == 0);
    if (w == 0) begin
      clip = 1;
      r.warped_x = xn < 0 ? ppt_pkg::SatMin : ppt_pkg::SatMax;
      r.warped_y = yn < 0 ? ppt_pkg::SatMin : ppt_pkg::SatMax;
      r.inv_w    = ppt_pkg::SatMax;
    end else begin
      r.warped_x = quot_q16(xn, w, clip);
      r.warped_y = quot_q16(yn, w, clip);
      r.inv_w    = quot_q16(ppt_pkg::OneQ38, w, clip);
    end
    r.clipped = clip;
    return r;
  endfunction

  // ---------------------------------------------------------------- monitors
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      if (typed_pending) warp_expected.push_back(typed_result);
      else warp_expected.push_back(warp_point(in_data));
    end
  end

  always @(posedge clk) begin
    ppt_pkg::point_out_t e;
    if (!rst && out_valid && out_ready) begin
      if (warp_expected.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = warp_expected.pop_front();
        if (out_data.warped_x !== e.warped_x || out_data.warped_y !== e.warped_y ||
            out_data.inv_w !== e.inv_w || out_data.w_zero !== e.w_zero ||
            out_data.clipped !== e.clipped) begin
          $display("%0t: mismatch exp x=%0d y=%0d iw=%0d wz=%b cl=%b", $time,
                   e.warped_x, e.warped_y, e.inv_w, e.w_zero, e.clipped);
          $display("%0t:          got x=%0d y=%0d iw=%0d wz=%b cl=%b", $time,
                   out_data.warped_x, out_data.warped_y, out_data.inv_w,
                   out_data.w_zero, out_data.clipped);
          errors++;
        end
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) out_ready <= ($urandom_range(99) >= out_stall_pct);

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_point(ppt_pkg::point_in_t p, bit typed, ppt_pkg::point_out_t res);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= p;
    typed_pending <= typed;
    typed_result <= res;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Called at a falling edge; valid drops for one cycle after the transfer
  task automatic write_reg(logic [ppt_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= ppt_pkg::REG_COEF_WY) coef_shadow[idx] = val;
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (warp_expected.size() != 0) @(negedge clk);
  endtask

  task automatic load_coefs(ppt_pkg::coef_t c);
    wait_idle();
    write_reg(ppt_pkg::REG_COEF_XX, c.xx);
    write_reg(ppt_pkg::REG_COEF_XY, c.xy);
    write_reg(ppt_pkg::REG_COEF_XT, c.xt);
    write_reg(ppt_pkg::REG_COEF_YX, c.yx);
    write_reg(ppt_pkg::REG_COEF_YY, c.yy);
    write_reg(ppt_pkg::REG_COEF_YT, c.yt);
    write_reg(ppt_pkg::REG_COEF_WX, c.wx);
    write_reg(ppt_pkg::REG_COEF_WY, c.wy);
  endtask

  function automatic logic signed [31:0] rand_coord(int kind);
    unique case (kind)
      0:       return $urandom;
      1:       return $signed($urandom_range(2097151)) - 32'sd1048576;
      2:       return $signed($urandom_range(255)) - 32'sd128;
      default: return $urandom_range(1) ? ppt_pkg::SatMax - $urandom_range(3)
                                        : ppt_pkg::SatMin + $urandom_range(3);
    endcase
  endfunction

  function automatic ppt_pkg::coef_t rand_coefs(int kind);
    ppt_pkg::coef_t c;
    c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    unique case (kind)
      0: ;
      1: begin
        // mild keystone around identity
        c.xx = OneQ24 + ($signed($urandom_range(1 << 23)) - (32'sd1 << 22));
        c.yy = OneQ24 + ($signed($urandom_range(1 << 23)) - (32'sd1 << 22));
        c.xy = $signed($urandom_range(1 << 22)) - (32'sd1 << 21);
        c.yx = $signed($urandom_range(1 << 22)) - (32'sd1 << 21);
        c.wx = $signed($urandom_range(1 << 10)) - (32'sd1 << 9);
        c.wy = $signed($urandom_range(1 << 10)) - (32'sd1 << 9);
      end
      2: c = {8{ppt_pkg::SatMax}};
      3: c = {8{ppt_pkg::SatMin}};
      default: c = '0;
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------- stimulus
  initial begin
    dir_row_t rows [$];
    dir_row_t r;
    ppt_pkg::coef_t ident, persp;
    ppt_pkg::point_in_t p;
    ppt_pkg::point_out_t none;
    int ck, pk;

    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    none = '0;
    ident = '{xx: OneQ24, yy: OneQ24, default: '0};
    persp = '{xx: OneQ24, yy: OneQ24, wx: -OneQ24, default: '0};
    for (int i = 0; i < 8; i++) coef_shadow[i] = '0;
    coef_shadow[ppt_pkg::REG_COEF_XX] = OneQ24;
    coef_shadow[ppt_pkg::REG_COEF_YY] = OneQ24;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Identity after reset: the point passes through, inv_w is 1.0
    r = '{load: 0, coefs: ident, pt: '0, typed: 1, res: '0};
    r.pt = '{ppt_pkg::SatMax, ppt_pkg::SatMin};
    r.res = '{ppt_pkg::SatMax, ppt_pkg::SatMin, OneQ16, 1'b0, 1'b0}; rows.push_back(r);
    r.pt = '{ppt_pkg::SatMin, ppt_pkg::SatMax};
    r.res = '{ppt_pkg::SatMin, ppt_pkg::SatMax, OneQ16, 1'b0, 1'b0}; rows.push_back(r);
    r.pt = '{0, 0};           r.res = '{0, 0, OneQ16, 1'b0, 1'b0};           rows.push_back(r);
    r.pt = '{1, -1};          r.res = '{1, -1, OneQ16, 1'b0, 1'b0};          rows.push_back(r);
    r.pt = '{OneQ16, -OneQ16}; r.res = '{OneQ16, -OneQ16, OneQ16, 1'b0, 1'b0}; rows.push_back(r);
    // w = 1 - x: zero at x = 1.0 with both numerators non-negative
    r.load = 1; r.coefs = persp; r.pt = '{OneQ16, 0};
    r.res = '{ppt_pkg::SatMax, ppt_pkg::SatMax, ppt_pkg::SatMax, 1'b1, 1'b1}; rows.push_back(r);
    r.load = 0; r.typed = 0;
    r.pt = '{OneQ16, -OneQ16};      rows.push_back(r);   // zero w, negative y numerator
    r.pt = '{OneQ16 - 1, 0};        rows.push_back(r);   // tiny w, overflow
    r.pt = '{-OneQ16, OneQ16};      rows.push_back(r);
    r.pt = '{OneQ16 + 1, 5};        rows.push_back(r);   // tiny negative w
    r.pt = '{ppt_pkg::SatMax, ppt_pkg::SatMin}; rows.push_back(r);
    r.pt = '{ppt_pkg::SatMin, ppt_pkg::SatMax}; rows.push_back(r);
    // Extreme coefficient sets
    r.load = 1; r.coefs = {8{ppt_pkg::SatMax}};
    r.pt = '{ppt_pkg::SatMax, ppt_pkg::SatMax}; rows.push_back(r);
    r.load = 0; r.pt = '{ppt_pkg::SatMin, 0}; rows.push_back(r);
    r.load = 1; r.coefs = {8{ppt_pkg::SatMin}};
    r.pt = '{ppt_pkg::SatMin, ppt_pkg::SatMin}; rows.push_back(r);
    r.load = 0; r.pt = '{ppt_pkg::SatMax, 1}; rows.push_back(r);
    r.load = 1; r.coefs = '0; r.pt = '{12345, -678}; rows.push_back(r);

    foreach (rows[i]) begin
      if (rows[i].load) load_coefs(rows[i].coefs);
      send_point(rows[i].pt, rows[i].typed, rows[i].typed ? rows[i].res : none);
    end
    wait_idle();
    typed_pending <= 0;
    // Writes past the register list must be ignored
    write_reg(RegPastEnd, $urandom);
    write_reg(ppt_pkg::REG_COEF_WY + 4'd1, $urandom);

    // Random phases, cycling through the idling modes
    for (int ph = 0; ph < 16; ph++) begin
      unique case (ph % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 67; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 67; end
        default: begin in_idle_pct = 18; out_stall_pct = 18; end
      endcase
      ck = (ph < 12) ? (ph % 2 == 0 ? 1 : 0) : ph - 10;
      load_coefs(rand_coefs(ck));
      if ($urandom_range(3) == 0)
        write_reg(ppt_pkg::CfgIdxW'($urandom_range(15, 8)), $urandom);
      for (int n = 0; n < 106; n++) begin
        pk = $urandom_range(9);
        pk = pk < 3 ? 0 : (pk < 7 ? 1 : (pk < 9 ? 2 : 3));
        p.point_x = rand_coord(pk);
        p.point_y = rand_coord(pk);
        send_point(p, 0, none);
      end
    end

    wait_idle();
    repeat (Drain) @(negedge clk);
    if (errors == 0 && warp_expected.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
